FILE: hdl/lces_pkg.sv
// ----------------------------------------------------------------------------
// Lattice color exchange store: shared types and constants
// Transaction payloads, mode codes, sequencer states and fixed limits.
// ----------------------------------------------------------------------------
package lces_pkg;

	typedef enum logic [1:0] {
		MODE_LOAD      = 2'd0,
		MODE_PROPOSE   = 2'd1,
		MODE_COMMIT    = 2'd2,
		MODE_CORRELATE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROP_A,
		ST_PROP_B,
		ST_COMMIT_A,
		ST_COMMIT_B,
		ST_CORR,
		ST_DONE
	} state_t;

	typedef struct packed {
		mode_t      mode;
		logic [5:0] site_a;
		logic [1:0] slot_a;
		logic [5:0] site_b;
		logic [1:0] slot_b;
		logic [2:0] load_color;
	} item_t;

	typedef struct packed {
		logic [2:0] color_a;
		logic [2:0] color_b;
		logic       forbidden;
		logic       same_color;
		logic [4:0] match_count;
		logic       status;
	} result_t;

	localparam logic       STATUS_OK          = 1'b0;
	localparam logic       STATUS_NO_PENDING  = 1'b1;
	localparam logic [2:0] SLOTS_IN_USE_RESET = 3'd4;
	localparam logic [4:0] COUNT_MAX          = 5'd31;

endpackage

FILE: hdl/lces_match.sv
// ----------------------------------------------------------------------------
// Lattice color exchange store: row compare unit
// Compares one color against each active, unskipped slot of a row; counts hits.
// ----------------------------------------------------------------------------
module lces_match #(
	parameter int SLOTS = 4,
	parameter int CW    = 3,
	parameter int PW    = 2,
	parameter int MW    = 3
) (
	input  logic [CW-1:0]            color,
	input  logic [SLOTS-1:0][CW-1:0] row,
	input  logic [MW-1:0]            active,
	input  logic                     skip_en,
	input  logic [PW-1:0]            skip_slot,
	output logic [SLOTS-1:0]         hits,
	output logic [MW-1:0]            count
);

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			hits[i] = (row[i] == color) && (MW'(i) < active)
				&& !(skip_en && (PW'(i) == skip_slot));
		end
		count = MW'($countones(hits));
	end

endmodule

FILE: hdl/lattice_color_exchange_store.sv
// ----------------------------------------------------------------------------
// Lattice color exchange store
// Holds one color per (site, slot) and serves load, propose, commit and
// correlate transactions on that table.
// ----------------------------------------------------------------------------
// Items arrive on the item channel and each one yields exactly one result on
// the result channel; fields a mode does not produce are zero. The cfg channel
// writes the active slot count and is always ready. The table is a memory of
// one row per site, written one slot per cycle and read at two rows per cycle
// with registered data; a shared row compare unit does all row color checks.
// Load and a commit with nothing pending go to ST_DONE. A pending commit
// writes in ST_COMMIT_A/B, propose checks in ST_PROP_A/B, and correlate steps
// the compare unit once per active slot of the first site. The block takes one
// item at a time and is ready again when the result enters the output
// register, so a new item may be accepted while that result waits.
// When the receiver stalls, the finished result is held in the output register
// and a following result waits in its final step. Reset clears the sequencer,
// the pending proposal and the output valid, and sets the slot count to four;
// table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module lattice_color_exchange_store #(
	parameter int SITES  = 64,
	parameter int SLOTS  = 4,
	parameter int COLORS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  lces_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_ready,
	output lces_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_data
);

	import lces_pkg::*;

	localparam int SW = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(COLORS);
	localparam int MW = $clog2(SLOTS + 1);

	typedef logic [SLOTS-1:0][CW-1:0] row_t;

	logic [SW-1:0] site_lut [64];
	logic [PW-1:0] slot_lut [4];

	for (genvar gi = 0; gi < 64; gi++) begin : g_site_lut
		assign site_lut[gi] = SW'(gi % SITES);
	end
	for (genvar gj = 0; gj < 4; gj++) begin : g_slot_lut
		assign slot_lut[gj] = PW'(gj % SLOTS);
	end

	state_t state_q, state_d;

	row_t          mem [SITES];
	row_t          rd_a_q, rd_b_q;
	logic [2:0]    cfg_q;
	logic [MW-1:0] active;

	mode_t         mode_q;
	logic [SW-1:0] site_a_q, site_b_q;
	logic [PW-1:0] slot_a_q, slot_b_q;
	logic [MW-1:0] p_q;
	logic [4:0]    cnt_q;
	logic          flag_q;
	logic          err_q;

	logic          pending_valid_q;
	logic [SW-1:0] pending_site_a_q, pending_site_b_q;
	logic [PW-1:0] pending_slot_a_q, pending_slot_b_q;
	logic [CW-1:0] pending_color_a_q, pending_color_b_q;

	logic          result_valid_q;
	result_t       result_q, result_d;

	logic          accept, out_free, load_out, corr_last;
	logic          wr_en;
	logic [SW-1:0] wr_site, rd_site_a, rd_site_b;
	logic [PW-1:0] wr_slot;
	logic [CW-1:0] wr_color, load_color_clamped;
	logic [CW-1:0] ca, cb;

	logic [CW-1:0]    cmp_color;
	row_t             cmp_row;
	logic             cmp_skip_en;
	logic [PW-1:0]    cmp_skip;
	logic [SLOTS-1:0] cmp_hits;
	logic [MW-1:0]    cmp_count;
	logic [5:0]       cnt_sum;

	lces_match #(
		.SLOTS(SLOTS),
		.CW   (CW),
		.PW   (PW),
		.MW   (MW)
	) u_match (
		.color    (cmp_color),
		.row      (cmp_row),
		.active   (active),
		.skip_en  (cmp_skip_en),
		.skip_slot(cmp_skip),
		.hits     (cmp_hits),
		.count    (cmp_count)
	);

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		if (cfg_q == 3'd0) begin
			active = MW'(1);
		end else if (int'(cfg_q) > SLOTS) begin
			active = MW'(SLOTS);
		end else begin
			active = MW'(cfg_q);
		end
	end

	always_comb begin
		if (int'(item.load_color) > COLORS - 1) begin
			load_color_clamped = CW'(COLORS - 1);
		end else begin
			load_color_clamped = CW'(item.load_color);
		end
	end

	assign ca        = rd_a_q[slot_a_q];
	assign cb        = rd_b_q[slot_b_q];
	assign accept    = item_valid && item_ready;
	assign out_free  = !result_valid_q || result_ready;
	assign corr_last = (p_q == active - MW'(1));
	assign cnt_sum   = 6'(cnt_q) + 6'(cmp_count);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					case (item.mode)
						MODE_LOAD:    state_d = ST_DONE;
						MODE_PROPOSE: state_d = ST_PROP_A;
						MODE_COMMIT:  state_d = pending_valid_q ? ST_COMMIT_A : ST_DONE;
						default:      state_d = ST_CORR;
					endcase
				end
			end
			ST_PROP_A:   state_d = ST_PROP_B;
			ST_PROP_B:   state_d = ST_DONE;
			ST_COMMIT_A: state_d = ST_COMMIT_B;
			ST_COMMIT_B: state_d = ST_DONE;
			ST_CORR:     state_d = corr_last ? ST_DONE : ST_CORR;
			ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready  = 1'b0;
		load_out    = 1'b0;
		wr_en       = 1'b0;
		wr_site     = pending_site_a_q;
		wr_slot     = pending_slot_a_q;
		wr_color    = pending_color_b_q;
		rd_site_a   = site_a_q;
		rd_site_b   = site_b_q;
		cmp_color   = rd_a_q[p_q[PW-1:0]];
		cmp_row     = rd_b_q;
		cmp_skip_en = 1'b0;
		cmp_skip    = slot_b_q;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				rd_site_a  = site_lut[item.site_a];
				rd_site_b  = site_lut[item.site_b];
				wr_en      = item_valid && (item.mode == MODE_LOAD);
				wr_site    = site_lut[item.site_a];
				wr_slot    = slot_lut[item.slot_a];
				wr_color   = load_color_clamped;
			end
			ST_PROP_A: begin
				cmp_color   = cb;
				cmp_row     = rd_a_q;
				cmp_skip_en = 1'b1;
				cmp_skip    = slot_a_q;
			end
			ST_PROP_B: begin
				cmp_color   = ca;
				cmp_row     = rd_b_q;
				cmp_skip_en = 1'b1;
				cmp_skip    = slot_b_q;
			end
			ST_COMMIT_A: begin
				wr_en = 1'b1;
			end
			ST_COMMIT_B: begin
				wr_en    = 1'b1;
				wr_site  = pending_site_b_q;
				wr_slot  = pending_slot_b_q;
				wr_color = pending_color_a_q;
			end
			ST_CORR: begin
			end
			ST_DONE: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result_d = '0;
		case (mode_q)
			MODE_PROPOSE: begin
				result_d.color_a    = 3'(ca);
				result_d.color_b    = 3'(cb);
				result_d.forbidden  = flag_q;
				result_d.same_color = (ca == cb);
			end
			MODE_COMMIT: begin
				result_d.status = err_q ? STATUS_NO_PENDING : STATUS_OK;
			end
			MODE_CORRELATE: begin
				result_d.match_count = cnt_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_site][wr_slot] <= wr_color;
		end
		rd_a_q <= mem[rd_site_a];
		rd_b_q <= mem[rd_site_b];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= item.mode;
			site_a_q <= site_lut[item.site_a];
			slot_a_q <= slot_lut[item.slot_a];
			site_b_q <= site_lut[item.site_b];
			slot_b_q <= slot_lut[item.slot_b];
			p_q      <= '0;
			cnt_q    <= '0;
			flag_q   <= 1'b0;
			err_q    <= (item.mode == MODE_COMMIT) && !pending_valid_q;
		end
		if (state_q == ST_PROP_A) begin
			flag_q <= |cmp_hits;
		end
		if (state_q == ST_PROP_B) begin
			flag_q <= flag_q | (|cmp_hits);
		end
		if (state_q == ST_CORR) begin
			p_q   <= p_q + MW'(1);
			cnt_q <= (cnt_sum > 6'(COUNT_MAX)) ? COUNT_MAX : cnt_sum[4:0];
		end
		if (load_out) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			result_valid_q    <= 1'b0;
			cfg_q             <= SLOTS_IN_USE_RESET;
			pending_valid_q   <= 1'b0;
			pending_site_a_q  <= '0;
			pending_slot_a_q  <= '0;
			pending_site_b_q  <= '0;
			pending_slot_b_q  <= '0;
			pending_color_a_q <= '0;
			pending_color_b_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			if (state_q == ST_PROP_A) begin
				pending_valid_q   <= 1'b1;
				pending_site_a_q  <= site_a_q;
				pending_slot_a_q  <= slot_a_q;
				pending_site_b_q  <= site_b_q;
				pending_slot_b_q  <= slot_b_q;
				pending_color_a_q <= ca;
				pending_color_b_q <= cb;
			end
			if (state_q == ST_COMMIT_B) begin
				pending_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/lces_checker.sv
// ----------------------------------------------------------------------------
// Lattice color exchange store: port checker
// Watches the top level's channels and flags behavior the block must not show.
// ----------------------------------------------------------------------------
module lces_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input lces_pkg::result_t result
);

	import lces_pkg::*;

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while busy");

	// A no-pending commit status never comes with propose or correlate fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status |->
			!result.forbidden && !result.same_color && (result.match_count == 5'd0)
			&& (result.color_a == 3'd0) && (result.color_b == 3'd0))
		else $error("status mixed with other fields");

	// same_color may only be set when the two colors are equal.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.same_color |-> result.color_a == result.color_b)
		else $error("same_color set on different colors");

endmodule

bind lattice_color_exchange_store lces_checker u_lces_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

FILE: bench/lattice_color_exchange_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice color exchange store testbench
// Drives load, propose, commit and correlate transactions with random gaps
// and receiver stalls, tracks the color table, the pending exchange and the
// active slot count in a mirror, and checks every result field by field.
// ----------------------------------------------------------------------------
import lces_pkg::*;

class lattice_mirror;
	logic [2:0] colors [256];
	bit         written [256];
	logic [2:0] slots_raw;
	bit         pend_valid;
	logic [5:0] pend_site_a;
	logic [1:0] pend_slot_a;
	logic [5:0] pend_site_b;
	logic [1:0] pend_slot_b;
	logic [2:0] pend_color_a;
	logic [2:0] pend_color_b;
	result_t    predicted_results [$];
	int         mismatches;

	function new();
		slots_raw = SLOTS_IN_USE_RESET;
		pend_valid = 1'b0;
		mismatches = 0;
		foreach (written[i]) begin
			written[i] = 1'b0;
			colors[i] = '0;
		end
	endfunction

	function int unsigned active_slots();
		if (slots_raw == 3'd0) return 1;
		if (slots_raw > 3'd4) return 4;
		return slots_raw;
	endfunction

	function bit color_elsewhere(logic [5:0] site, logic [1:0] skip, logic [2:0] color);
		int unsigned i;
		for (i = 0; i < active_slots(); i++) begin
			if (i != skip && colors[{site, 2'(i)}] == color) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Returns the first table entry the transaction would read before it was
	// ever loaded, or 256 when every entry it reads holds a known color.
	function int unsigned first_unwritten(item_t it);
		int unsigned i;
		if (it.mode == MODE_PROPOSE) begin
			if (!written[{it.site_a, it.slot_a}]) return {it.site_a, it.slot_a};
			if (!written[{it.site_b, it.slot_b}]) return {it.site_b, it.slot_b};
		end
		if (it.mode == MODE_PROPOSE || it.mode == MODE_CORRELATE) begin
			for (i = 0; i < active_slots(); i++) begin
				if (!written[{it.site_a, 2'(i)}]) return {it.site_a, 2'(i)};
				if (!written[{it.site_b, 2'(i)}]) return {it.site_b, 2'(i)};
			end
		end
		return 256;
	endfunction

	function void apply_item(item_t it);
		result_t     r;
		logic [2:0]  ca;
		logic [2:0]  cb;
		logic [4:0]  count;
		int unsigned p0;
		int unsigned p1;
		r = '0;
		case (it.mode)
			MODE_LOAD: begin
				colors[{it.site_a, it.slot_a}] = it.load_color;
				written[{it.site_a, it.slot_a}] = 1'b1;
			end
			MODE_PROPOSE: begin
				ca = colors[{it.site_a, it.slot_a}];
				cb = colors[{it.site_b, it.slot_b}];
				pend_site_a = it.site_a;
				pend_slot_a = it.slot_a;
				pend_site_b = it.site_b;
				pend_slot_b = it.slot_b;
				pend_color_a = ca;
				pend_color_b = cb;
				pend_valid = 1'b1;
				r.color_a = ca;
				r.color_b = cb;
				r.forbidden = color_elsewhere(it.site_a, it.slot_a, cb)
					| color_elsewhere(it.site_b, it.slot_b, ca);
				r.same_color = (ca == cb);
			end
			MODE_COMMIT: begin
				if (!pend_valid) begin
					r.status = STATUS_NO_PENDING;
				end else begin
					colors[{pend_site_a, pend_slot_a}] = pend_color_b;
					colors[{pend_site_b, pend_slot_b}] = pend_color_a;
					pend_valid = 1'b0;
				end
			end
			default: begin
				count = '0;
				for (p0 = 0; p0 < active_slots(); p0++) begin
					for (p1 = 0; p1 < active_slots(); p1++) begin
						if (colors[{it.site_a, 2'(p0)}] == colors[{it.site_b, 2'(p1)}]
								&& count < COUNT_MAX) begin
							count++;
						end
					end
				end
				r.match_count = count;
			end
		endcase
		predicted_results.push_back(r);
	endfunction

	function void compare(string field, logic [4:0] want, logic [4:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			mismatches++;
		end
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (predicted_results.size() == 0) begin
			$error("result transaction %h arrived with no prediction waiting", got);
			mismatches++;
			return;
		end
		want = predicted_results.pop_front();
		compare("color_a", want.color_a, got.color_a);
		compare("color_b", want.color_b, got.color_b);
		compare("forbidden", want.forbidden, got.forbidden);
		compare("same_color", want.same_color, got.same_color);
		compare("match_count", want.match_count, got.match_count);
		compare("status", want.status, got.status);
	endfunction
endclass

module lattice_color_exchange_store_tb;

	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 150;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;
	logic    cfg_valid;
	logic    cfg_ready;
	logic [2:0] cfg_data;

	lattice_mirror mirror = new();
	bit            steady;
	bit            last_proposed;
	int            quiet_cycles;

	logic [2:0] phase_slots [8] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd7, 3'd5, 3'd6};

	lattice_color_exchange_store dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic item_t cmd(mode_t mode, logic [5:0] sa, logic [1:0] pa,
			logic [5:0] sb, logic [1:0] pb, logic [2:0] color);
		item_t it;
		it.mode = mode;
		it.site_a = sa;
		it.slot_a = pa;
		it.site_b = sb;
		it.slot_b = pb;
		it.load_color = color;
		return it;
	endfunction

	function automatic logic [5:0] draw_site();
		if ($urandom_range(1) == 0) return 6'($urandom_range(3));
		return 6'($urandom_range(63));
	endfunction

	// Proposals are usually followed by a commit so that exchanges actually
	// land in the table; the rest is a free mix of all four modes.
	function automatic item_t random_item();
		item_t       it;
		int unsigned pick;
		int unsigned miss;
		it = cmd(MODE_LOAD, draw_site(), 2'($urandom_range(3)), draw_site(),
			2'($urandom_range(3)), 3'($urandom_range(7)));
		pick = $urandom_range(99);
		if (last_proposed && pick < 60) it.mode = MODE_COMMIT;
		else if (pick < 25) it.mode = MODE_LOAD;
		else if (pick < 60) it.mode = MODE_PROPOSE;
		else if (pick < 80) it.mode = MODE_COMMIT;
		else it.mode = MODE_CORRELATE;
		miss = mirror.first_unwritten(it);
		if (miss < 256) begin
			it.mode = MODE_LOAD;
			it.site_a = miss[7:2];
			it.slot_a = miss[1:0];
		end
		last_proposed = (it.mode == MODE_PROPOSE);
		return it;
	endfunction

	task automatic drive_item(input item_t it);
		int gap;
		gap = steady ? 0 : $urandom_range(12);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		mirror.apply_item(it);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (mirror.predicted_results.size() != 0);
	endtask

	task automatic write_slots(input logic [2:0] value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mirror.slots_raw = value;
	endtask

	initial begin : result_side
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(12);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) mirror.check_result(result);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int phase;
		int k;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		steady = 1'b0;
		last_proposed = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		drive_item(cmd(MODE_COMMIT, 6'd63, 2'd3, 6'd63, 2'd3, 3'd7));
		drive_item(cmd(MODE_LOAD, 6'd0, 2'd0, 6'd63, 2'd3, 3'd0));
		drive_item(cmd(MODE_LOAD, 6'd0, 2'd1, 6'd0, 2'd0, 3'd1));
		drive_item(cmd(MODE_LOAD, 6'd0, 2'd2, 6'd0, 2'd0, 3'd2));
		drive_item(cmd(MODE_LOAD, 6'd0, 2'd3, 6'd0, 2'd0, 3'd3));
		drive_item(cmd(MODE_LOAD, 6'd63, 2'd0, 6'd0, 2'd0, 3'd7));
		drive_item(cmd(MODE_LOAD, 6'd63, 2'd1, 6'd0, 2'd0, 3'd6));
		drive_item(cmd(MODE_LOAD, 6'd63, 2'd2, 6'd0, 2'd0, 3'd5));
		drive_item(cmd(MODE_LOAD, 6'd63, 2'd3, 6'd0, 2'd0, 3'd4));
		drive_item(cmd(MODE_PROPOSE, 6'd0, 2'd0, 6'd63, 2'd3, 3'd0));
		drive_item(cmd(MODE_COMMIT, 6'd0, 2'd0, 6'd0, 2'd0, 3'd0));
		// A load between propose and commit must not disturb the latched colors.
		drive_item(cmd(MODE_PROPOSE, 6'd0, 2'd1, 6'd63, 2'd1, 3'd7));
		drive_item(cmd(MODE_LOAD, 6'd0, 2'd1, 6'd63, 2'd3, 3'd5));
		drive_item(cmd(MODE_COMMIT, 6'd0, 2'd0, 6'd0, 2'd0, 3'd0));
		drive_item(cmd(MODE_COMMIT, 6'd0, 2'd0, 6'd0, 2'd0, 3'd0));
		drive_item(cmd(MODE_PROPOSE, 6'd0, 2'd2, 6'd0, 2'd3, 3'd0));
		drive_item(cmd(MODE_COMMIT, 6'd0, 2'd0, 6'd0, 2'd0, 3'd0));
		drive_item(cmd(MODE_PROPOSE, 6'd63, 2'd0, 6'd63, 2'd0, 3'd0));
		drive_item(cmd(MODE_COMMIT, 6'd0, 2'd0, 6'd0, 2'd0, 3'd0));
		drive_item(cmd(MODE_CORRELATE, 6'd0, 2'd0, 6'd63, 2'd0, 3'd0));
		drive_item(cmd(MODE_CORRELATE, 6'd63, 2'd3, 6'd63, 2'd3, 3'd7));
		drive_item(cmd(MODE_PROPOSE, 6'd0, 2'd3, 6'd63, 2'd2, 3'd0));

		for (phase = 0; phase < 8; phase++) begin
			write_slots(phase_slots[phase]);
			steady = (phase == 3);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2) wait_drained();
				drive_item(random_item());
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.predicted_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
